// File: rtl/core/rfc_pkg.sv
// Shared types and command codes for the rectangle fill/clear engine.
`timescale 1ns / 1ps

package rfc_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ADDR,
        ST_WALK,
        ST_READ,
        ST_DONE
    } rfc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rfc_walk_status_t;

endpackage

// File: rtl/core/rfc_raster.sv
// Raster walker: steps the frame memory write address over a rectangle, one pixel a cycle.
`timescale 1ns / 1ps

module rfc_raster
    import rfc_pkg::*;
#(
    parameter int FRAME_W = 320,
    parameter int FRAME_H = 240
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [$clog2(FRAME_W+1)-1:0]               cols,
    input  logic [$clog2(FRAME_H+1)-1:0]               rows,
    input  logic [((FRAME_W*FRAME_H > 1) ? $clog2(FRAME_W*FRAME_H) : 1)-1:0] base,
    output logic                                       wr_en,
    output logic [((FRAME_W*FRAME_H > 1) ? $clog2(FRAME_W*FRAME_H) : 1)-1:0] wr_addr,
    output rfc_walk_status_t                           status
);

    localparam int XW    = $clog2(FRAME_W + 1);
    localparam int YW    = $clog2(FRAME_H + 1);
    localparam int DEPTH = FRAME_W * FRAME_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          active_reg;
    logic          done_reg;
    logic [XW-1:0] col_reg;
    logic [XW-1:0] cols_reg;
    logic [YW-1:0] row_reg;
    logic [YW-1:0] rows_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] row_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
            end else if (active_reg && col_reg == cols_reg - XW'(1)
                         && row_reg == rows_reg - YW'(1)) begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            col_reg      <= '0;
            row_reg      <= '0;
            cols_reg     <= cols;
            rows_reg     <= rows;
            addr_reg     <= base;
            row_addr_reg <= base;
        end else if (active_reg) begin
            if (col_reg == cols_reg - XW'(1)) begin
                // wrap to the first column of the next row
                col_reg      <= '0;
                row_reg      <= row_reg + YW'(1);
                row_addr_reg <= row_addr_reg + AW'(FRAME_W);
                addr_reg     <= row_addr_reg + AW'(FRAME_W);
            end else begin
                col_reg  <= col_reg + XW'(1);
                addr_reg <= addr_reg + AW'(1);
            end
        end
    end

    assign wr_en       = active_reg;
    assign wr_addr     = addr_reg;
    assign status.busy = active_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/core/rect_fill_clear_rgb565_unit.sv
// Top level of the rectangle fill/clear engine with its RGB565 frame memory.
`timescale 1ns / 1ps

// Owns a FRAME_W x FRAME_H RGB565 frame memory (row-major, single port for
// writes, registered read). Commands arrive on the s_ stream, one result per
// command leaves on the m_ stream. Clear packs the RGB888 color to 565 and
// writes every pixel; fill writes the same packed color into the rectangle
// clipped to the frame; read returns one pixel and whether it lay in frame.
// The speed of clear and fill is set by the one-pixel-per-cycle write port
// of the frame memory. One command is worked at a time; the next is taken
// as soon as the previous result is registered, even if it has not been
// consumed. Memory contents after reset are undefined; no clearing pass
// runs.
module rect_fill_clear_rgb565_unit
    import rfc_pkg::*;
#(
    parameter int FRAME_W = 320,
    parameter int FRAME_H = 240
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // left, top, span_w, span_h, red_in, green_in, blue_in
    input  logic [1:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // pixel_out
    output logic [0:0]  m_tuser   // in_frame
);

    localparam int XW    = $clog2(FRAME_W + 1);
    localparam int YW    = $clog2(FRAME_H + 1);
    localparam int DEPTH = FRAME_W * FRAME_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [17:0] FW_S = 18'(FRAME_W);
    localparam logic signed [17:0] FH_S = 18'(FRAME_H);

    rfc_state_t state_reg, state_next;

    logic [1:0]         cmd_reg;
    logic signed [15:0] left_reg, top_reg, span_w_reg, span_h_reg;
    logic [15:0]        color_reg;
    logic [XW-1:0]      x0_reg, cols_reg;
    logic [YW-1:0]      y0_reg, rows_reg;
    logic               draw_reg;
    logic               in_frame_reg;
    logic [AW-1:0]      base_reg;
    logic [15:0]        rd_data_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    logic               m_tuser_reg;

    logic [15:0] mem [DEPTH];

    logic               s_accept;
    logic               walk_start;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic               out_load;
    rfc_walk_status_t   walk_status;

    // clip arithmetic at full precision
    logic signed [17:0] lx, ty, sum_x, sum_y, x0c, y0c, x1c, y1c, dx, dy;
    logic               draw_x, draw_y, read_ok;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        lx     = 18'(left_reg);
        ty     = 18'(top_reg);
        sum_x  = lx + 18'(span_w_reg);
        sum_y  = ty + 18'(span_h_reg);
        x0c    = (lx < 0) ? '0 : lx;
        y0c    = (ty < 0) ? '0 : ty;
        x1c    = (sum_x > FW_S) ? FW_S : sum_x;
        y1c    = (sum_y > FH_S) ? FH_S : sum_y;
        dx     = x1c - x0c;
        dy     = y1c - y0c;
        draw_x = (x1c > x0c);
        draw_y = (y1c > y0c);
        read_ok = (lx >= 0) && (ty >= 0) && (lx < FW_S) && (ty < FH_S);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        walk_start = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                if (draw_reg) begin
                    walk_start = 1'b1;
                    state_next = ST_WALK;
                end else if (in_frame_reg) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                if (walk_status.done) state_next = ST_DONE;
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg    <= s_tuser;
            left_reg   <= s_tdata[15:0];
            top_reg    <= s_tdata[31:16];
            span_w_reg <= s_tdata[47:32];
            span_h_reg <= s_tdata[63:48];
            color_reg  <= {s_tdata[71:67], s_tdata[79:74], s_tdata[87:83]};
        end
        if (state_reg == ST_SETUP) begin
            case (cmd_reg)
                CMD_CLEAR: begin
                    x0_reg       <= '0;
                    y0_reg       <= '0;
                    cols_reg     <= XW'(FRAME_W);
                    rows_reg     <= YW'(FRAME_H);
                    draw_reg     <= 1'b1;
                    in_frame_reg <= 1'b0;
                end
                CMD_FILL: begin
                    x0_reg       <= x0c[XW-1:0];
                    y0_reg       <= y0c[YW-1:0];
                    cols_reg     <= dx[XW-1:0];
                    rows_reg     <= dy[YW-1:0];
                    draw_reg     <= draw_x && draw_y;
                    in_frame_reg <= 1'b0;
                end
                CMD_READ: begin
                    x0_reg       <= lx[XW-1:0];
                    y0_reg       <= ty[YW-1:0];
                    cols_reg     <= dx[XW-1:0];
                    rows_reg     <= dy[YW-1:0];
                    draw_reg     <= 1'b0;
                    in_frame_reg <= read_ok;
                end
                default: begin
                    x0_reg       <= '0;
                    y0_reg       <= '0;
                    cols_reg     <= '0;
                    rows_reg     <= '0;
                    draw_reg     <= 1'b0;
                    in_frame_reg <= 1'b0;
                end
            endcase
        end
        if (state_reg == ST_ADDR) begin
            base_reg <= AW'(32'(y0_reg) * 32'(FRAME_W) + 32'(x0_reg));
        end
    end

    rfc_raster #(
        .FRAME_W (FRAME_W),
        .FRAME_H (FRAME_H)
    ) u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .cols    (cols_reg),
        .rows    (rows_reg),
        .base    (AW'(32'(y0_reg) * 32'(FRAME_W) + 32'(x0_reg))),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .status  (walk_status)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= color_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[base_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= in_frame_reg ? rd_data_reg : 16'h0000;
            m_tuser_reg <= in_frame_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_wr_only_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_WALK))
        else $error("frame write outside a walk");

    a_no_rd_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("read and write of frame memory in one cycle");

    a_wr_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_addr <= AW'(DEPTH - 1)))
        else $error("frame write address beyond the frame");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    a_zero_off_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == 16'h0000))
        else $error("nonzero pixel on a result without in_frame");

endmodule
